### rtl/ias_instruction_executor_top_macros.svh
// Assertion macros shared by the executor RTL.
`ifndef IAS_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define IAS_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define IAS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define IAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ias_pkg.sv
// ----------------------------------------------------------------------------
// IAS executor package
// Shared word types, kind codes, opcodes and status codes.
// ----------------------------------------------------------------------------
package ias_pkg;

  localparam int WordW = 40;
  localparam int AddrW = 12;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_EXEC  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  localparam logic [7:0] OP_LOAD     = 8'h01;
  localparam logic [7:0] OP_LOADNEG  = 8'h02;
  localparam logic [7:0] OP_LOADABS  = 8'h03;
  localparam logic [7:0] OP_LOADNABS = 8'h04;
  localparam logic [7:0] OP_ADD      = 8'h05;
  localparam logic [7:0] OP_ADDABS   = 8'h07;
  localparam logic [7:0] OP_SUBABS   = 8'h08;
  localparam logic [7:0] OP_LOADMQM  = 8'h09;
  localparam logic [7:0] OP_LOADMQ   = 8'h0A;
  localparam logic [7:0] OP_MUL      = 8'h0B;
  localparam logic [7:0] OP_DIV      = 8'h0C;
  localparam logic [7:0] OP_JUMPA    = 8'h0D;
  localparam logic [7:0] OP_JUMPB    = 8'h0E;
  localparam logic [7:0] OP_JUMPC    = 8'h0F;
  localparam logic [7:0] OP_STORFLD  = 8'h12;
  localparam logic [7:0] OP_LSH      = 8'h14;
  localparam logic [7:0] OP_RSH      = 8'h15;
  localparam logic [7:0] OP_STOR     = 8'h21;
  localparam logic [7:0] OP_SUB      = 8'h26;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIVZERO = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_JUMP    = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       opcode;
    logic [AddrW-1:0] address;
    word_t            write_value;
  } in_word_t;

  typedef struct packed {
    word_t      acc_value;
    word_t      mq_value;
    word_t      mem_word;
    logic [2:0] status;
  } out_word_t;

  // Request to the shift-and-add / restoring-divide unit.
  typedef struct packed {
    logic  start;
    logic  is_div;
    word_t a;
    word_t b;
  } arith_req_t;

  typedef struct packed {
    logic  done;
    word_t hi;
    word_t lo;
  } arith_rsp_t;

endpackage

### rtl/ias_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// IAS instruction executor
// Executes IAS instructions against ACC, MQ and a word memory.
// ----------------------------------------------------------------------------
// Usage: one input word per item on in_valid/in_stall carries kind, opcode,
// address and write data. Each item returns one output word on
// out_valid/out_stall with ACC, MQ, the memory word at the address after
// the item, and a status code.
// Sequencing: read and write items and simple instructions pass through the
// memory read, execute and write-back, and result states before out_valid.
// MUL and DIV also wait on the bit-serial multiply/divide unit, which
// retires one bit per cycle. One item is in flight at a time.
// Reset: ACC and MQ clear at once. The memory is then cleared by a pass over
// all MEM_DEPTH words, one word a cycle, during which in_stall stays high.
// Stall: a finished result waits in the output register while out_stall is
// high; the next item is accepted once that register is free or being taken.
// ----------------------------------------------------------------------------
module ias_instruction_executor_top #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ias_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ias_pkg::out_word_t out_data
);
  import ias_pkg::*;

  localparam int MemAw = $clog2(MEM_DEPTH);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_ARITH = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  word_t            mem [MEM_DEPTH];
  word_t            rdata_r;
  logic             mem_we;
  logic [MemAw-1:0] mem_wa;
  word_t            mem_wd;
  logic [MemAw-1:0] clr_r;
  in_word_t         item_r;
  word_t            acc_r, acc_nxt, mq_r, mq_nxt;
  logic [2:0]       st_nxt;
  logic             addr_ok;
  logic [MemAw-1:0] addr_idx;
  logic             uses_mem;
  word_t            m_abs;
  word_t            wb_word;
  logic             wb_we;
  logic             ovalid_r;
  out_word_t        odata_r;
  logic             res_ready;
  logic             res_load;
  word_t            res_mem;
  logic [2:0]       res_st;
  logic [2:0]       st_r;
  arith_req_t       areq;
  arith_rsp_t       arsp;

  ias_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign addr_ok  = {20'd0, item_r.address} < 32'(MEM_DEPTH);
  assign addr_idx = item_r.address[MemAw-1:0];
  assign m_abs    = rdata_r[WordW-1] ? word_t'(-rdata_r) : rdata_r;
  assign res_ready = !ovalid_r || !out_stall;

  always_comb begin
    unique case (item_r.opcode)
      OP_LOAD, OP_LOADNEG, OP_LOADABS, OP_LOADNABS, OP_ADD, OP_ADDABS,
      OP_SUBABS, OP_LOADMQM, OP_MUL, OP_DIV, OP_STORFLD, OP_STOR,
      OP_SUB: uses_mem = 1'b1;
      default: uses_mem = 1'b0;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    mq_nxt  = mq_r;
    st_nxt  = ST_OK;
    wb_we   = 1'b0;
    wb_word = rdata_r;
    if (item_r.kind == KIND_EXEC) begin
      if (item_r.opcode == OP_JUMPA || item_r.opcode == OP_JUMPB ||
          item_r.opcode == OP_JUMPC) begin
        st_nxt = ST_JUMP;
      end else if (uses_mem && !addr_ok) begin
        st_nxt = ST_BADADDR;
      end else begin
        unique case (item_r.opcode)
          OP_LOAD:     acc_nxt = rdata_r;
          OP_LOADNEG:  acc_nxt = word_t'(-rdata_r);
          OP_LOADABS:  acc_nxt = m_abs;
          OP_LOADNABS: acc_nxt = word_t'(-m_abs);
          OP_ADD:      acc_nxt = acc_r + rdata_r;
          OP_ADDABS:   acc_nxt = acc_r + m_abs;
          OP_SUB:      acc_nxt = acc_r - rdata_r;
          OP_SUBABS:   acc_nxt = acc_r - m_abs;
          OP_LOADMQM:  mq_nxt = rdata_r;
          OP_LOADMQ:   acc_nxt = mq_r;
          OP_MUL:      ;
          OP_DIV: begin
            if (rdata_r == '0) begin
              st_nxt = ST_DIVZERO;
            end
          end
          OP_LSH:      acc_nxt = {acc_r[WordW-2:0], 1'b0};
          OP_RSH:      acc_nxt = {1'b0, acc_r[WordW-1:1]};
          OP_STOR: begin
            wb_we   = 1'b1;
            wb_word = acc_r;
          end
          OP_STORFLD: begin
            wb_we   = 1'b1;
            wb_word = {rdata_r[39:32], acc_r[11:0], rdata_r[19:0]};
          end
          default:     st_nxt = ST_UNKNOWN;
        endcase
      end
    end else if (!addr_ok) begin
      st_nxt = ST_BADADDR;
    end else if (item_r.kind == KIND_WRITE) begin
      wb_we   = 1'b1;
      wb_word = item_r.write_value;
    end
  end

  always_comb begin
    areq.start  = 1'b0;
    areq.is_div = item_r.opcode == OP_DIV;
    areq.a      = item_r.opcode == OP_DIV ? acc_r : mq_r;
    areq.b      = rdata_r;
    state_nxt   = state_r;
    mem_we      = 1'b0;
    mem_wa      = addr_idx;
    mem_wd      = wb_word;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == MemAw'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (item_r.kind == KIND_EXEC && st_nxt == ST_OK &&
            (item_r.opcode == OP_MUL || item_r.opcode == OP_DIV)) begin
          areq.start = 1'b1;
          state_nxt  = S_ARITH;
        end else begin
          mem_we    = wb_we;
          state_nxt = S_RESP;
        end
      end
      S_ARITH: begin
        if (arsp.done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = state_r != S_IDLE;
  assign res_load = state_r == S_RESP && res_ready;
  assign res_mem  = addr_ok ? (wb_we ? wb_word : rdata_r) : '0;
  assign res_st   = st_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[addr_idx];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == S_EXEC) begin
      st_r <= st_nxt;
    end
    if (res_load) begin
      odata_r <= '{acc_value: acc_r, mq_value: mq_r, mem_word: res_mem,
                   status: res_st};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      acc_r    <= '0;
      mq_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_EXEC && st_nxt == ST_OK) begin
        acc_r <= acc_nxt;
        mq_r  <= mq_nxt;
      end else if (state_r == S_ARITH && arsp.done) begin
        if (item_r.opcode == OP_DIV) begin
          acc_r <= arsp.hi;
          mq_r  <= arsp.lo;
        end else begin
          acc_r <= arsp.hi;
          mq_r  <= arsp.lo;
        end
      end
      if (res_load) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  `include "ias_instruction_executor_top_macros.svh"

  `IAS_ASSERT_IMP(a_no_accept_in_flight, state_r != S_IDLE, in_stall)
  `IAS_ASSERT_IMP(a_clear_no_output, state_r == S_CLEAR, !in_valid || in_stall)
  `IAS_ASSERT_NEXT(a_hold_output, out_valid && out_stall && !res_load,
                   out_valid && $stable(out_data))

endmodule

### rtl/ias_arith.sv
// ----------------------------------------------------------------------------
// IAS multiply/divide unit
// Bit-serial unsigned 40x40 multiply and 40/40 restoring divide.
// ----------------------------------------------------------------------------
module ias_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  ias_pkg::arith_req_t req,
  output ias_pkg::arith_rsp_t rsp
);
  import ias_pkg::*;

  localparam int CntW = $clog2(WordW + 1);

  logic            busy_r, busy_nxt;
  logic            div_r;
  logic [CntW-1:0] cnt_r;
  word_t           hi_r, lo_r, b_r;
  logic            done_r;
  logic [WordW:0]  madd;
  logic [WordW:0]  rem_sh;
  logic [WordW:0]  rem_sub;

  always_comb begin
    madd    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, b_r} : '0);
    rem_sh  = {hi_r, lo_r[WordW-1]};
    rem_sub = rem_sh - {1'b0, b_r};
    busy_nxt = busy_r;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CntW'(WordW - 1)) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= busy_r && !req.start && cnt_r == CntW'(WordW - 1);
      if (req.start) begin
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.is_div;
      b_r   <= req.b;
      hi_r  <= '0;
      lo_r  <= req.a;
    end else if (busy_r) begin
      if (!div_r) begin
        hi_r <= madd[WordW:1];
        lo_r <= {madd[0], lo_r[WordW-1:1]};
      end else if (!rem_sub[WordW]) begin
        hi_r <= rem_sub[WordW-1:0];
        lo_r <= {lo_r[WordW-2:0], 1'b1};
      end else begin
        hi_r <= rem_sh[WordW-1:0];
        lo_r <= {lo_r[WordW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

  `include "ias_instruction_executor_top_macros.svh"

  `IAS_ASSERT_NEXT(a_done_ends_busy, rsp.done, !busy_r || req.start)
  `IAS_ASSERT_IMP(a_done_after_busy, rsp.done, $past(busy_r))
  `IAS_ASSERT_IMP(a_cnt_range, busy_r, cnt_r < CntW'(WordW))

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// IAS instruction executor testbench
// Drives instructions and memory accesses with random idling on both sides
// and checks every result word against a predictor of ACC, MQ and memory.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ias_pkg::*;

  localparam int MemDepth = 1024;
  localparam longint CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  word_t acc_model, mq_model;
  word_t mem_model [MemDepth];
  out_word_t pending_results [$];
  int errors = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;
  int stall_left = 0;

  ias_instruction_executor_top #(.MEM_DEPTH(MemDepth)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic word_t magnitude(word_t v);
    return v[WordW-1] ? -v : v;
  endfunction

  function automatic out_word_t execute_word(in_word_t w);
    out_word_t r;
    logic [2:0] st;
    logic ok_addr;
    logic [79:0] prod;
    word_t m;
    ok_addr = w.address < MemDepth;
    m = ok_addr ? mem_model[w.address] : '0;
    st = ST_OK;
    if (w.kind == KIND_EXEC) begin
      case (w.opcode)
        OP_JUMPA, OP_JUMPB, OP_JUMPC: st = ST_JUMP;
        OP_LOADMQ: acc_model = mq_model;
        OP_LSH: acc_model = acc_model << 1;
        OP_RSH: acc_model = acc_model >> 1;
        OP_LOAD, OP_LOADNEG, OP_LOADABS, OP_LOADNABS, OP_ADD, OP_ADDABS,
        OP_SUB, OP_SUBABS, OP_LOADMQM, OP_MUL, OP_DIV, OP_STOR, OP_STORFLD: begin
          if (!ok_addr) st = ST_BADADDR;
          else begin
            case (w.opcode)
              OP_LOAD: acc_model = m;
              OP_LOADNEG: acc_model = -m;
              OP_LOADABS: acc_model = magnitude(m);
              OP_LOADNABS: acc_model = -magnitude(m);
              OP_ADD: acc_model = acc_model + m;
              OP_ADDABS: acc_model = acc_model + magnitude(m);
              OP_SUB: acc_model = acc_model - m;
              OP_SUBABS: acc_model = acc_model - magnitude(m);
              OP_LOADMQM: mq_model = m;
              OP_MUL: begin
                prod = {40'd0, mq_model} * {40'd0, m};
                acc_model = prod[79:40];
                mq_model = prod[39:0];
              end
              OP_DIV: begin
                if (m == '0) st = ST_DIVZERO;
                else begin
                  mq_model = acc_model / m;
                  acc_model = acc_model % m;
                end
              end
              OP_STOR: mem_model[w.address] = acc_model;
              default: mem_model[w.address][31:20] = acc_model[11:0];
            endcase
          end
        end
        default: st = ST_UNKNOWN;
      endcase
    end else if (w.kind == KIND_WRITE) begin
      if (ok_addr) mem_model[w.address] = w.write_value;
      else st = ST_BADADDR;
    end else if (!ok_addr) begin
      st = ST_BADADDR;
    end
    r.acc_value = acc_model;
    r.mq_value = mq_model;
    r.mem_word = ok_addr ? mem_model[w.address] : '0;
    r.status = st;
    return r;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_word(w));
  endtask

  task automatic send(logic [1:0] k, logic [7:0] op, logic [11:0] a, word_t v);
    in_word_t w;
    w.kind = k;
    w.opcode = op;
    w.address = a;
    w.write_value = v;
    send_word(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_stall <= hold_off;
      stall_left <= 0;
    end else if (idle_on && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.acc_value !== e.acc_value) begin
          $error("acc_value expected %h actual %h", e.acc_value, out_data.acc_value);
          errors++;
        end
        if (out_data.mq_value !== e.mq_value) begin
          $error("mq_value expected %h actual %h", e.mq_value, out_data.mq_value);
          errors++;
        end
        if (out_data.mem_word !== e.mem_word) begin
          $error("mem_word expected %h actual %h", e.mem_word, out_data.mem_word);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  function automatic word_t random_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {1'b1, 39'd0};
      3: return word_t'($urandom_range(0, 15));
      default: return word_t'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [11:0] random_address();
    if ($urandom_range(0, 19) == 0) return 12'($urandom_range(MemDepth, 4095));
    return 12'($urandom_range(0, 15));
  endfunction

  task automatic test_directed();
    send(KIND_READ, 8'h00, 12'd0, '0);
    send(KIND_WRITE, 8'hFF, 12'd0, '1);
    send(KIND_WRITE, 8'h00, 12'd1023, {1'b1, 39'd5});
    send(KIND_WRITE, 8'h00, 12'd4095, '1);
    send(KIND_EXEC, OP_LOAD, 12'd0, '0);
    send(KIND_EXEC, OP_LOADNEG, 12'd1023, '0);
    send(KIND_EXEC, OP_LOADABS, 12'd1023, '0);
    send(KIND_EXEC, OP_LOADNABS, 12'd0, '0);
    send(KIND_EXEC, OP_ADD, 12'd0, '0);
    send(KIND_EXEC, OP_ADDABS, 12'd1023, '0);
    send(KIND_EXEC, OP_SUB, 12'd0, '0);
    send(KIND_EXEC, OP_SUBABS, 12'd1023, '0);
    send(KIND_EXEC, OP_LOADMQM, 12'd0, '0);
    send(KIND_EXEC, OP_MUL, 12'd0, '0);
    send(KIND_EXEC, OP_DIV, 12'd5, '0);
    send(KIND_EXEC, OP_DIV, 12'd1023, '0);
    send(KIND_EXEC, OP_LOADMQ, 12'd4095, '0);
    send(KIND_EXEC, OP_LSH, 12'd4095, '0);
    send(KIND_EXEC, OP_RSH, 12'd2048, '0);
    send(KIND_EXEC, OP_STOR, 12'd7, '0);
    send(KIND_EXEC, OP_STORFLD, 12'd0, '0);
    send(KIND_EXEC, OP_JUMPA, 12'd4095, '0);
    send(KIND_EXEC, OP_JUMPB, 12'd0, '0);
    send(KIND_EXEC, OP_JUMPC, 12'd0, '0);
    send(KIND_EXEC, 8'hFF, 12'd0, '0);
    send(KIND_SPARE, OP_ADD, 12'd1024, '1);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (8) send(KIND_READ, 8'h00, random_address(), '0);
    join
  endtask

  task automatic test_random(int n);
    logic [7:0] ops [20] = '{OP_LOAD, OP_LOADNEG, OP_LOADABS, OP_LOADNABS, OP_ADD,
      OP_ADDABS, OP_SUB, OP_SUBABS, OP_LOADMQM, OP_LOADMQ, OP_MUL, OP_DIV,
      OP_JUMPA, OP_JUMPB, OP_JUMPC, OP_STORFLD, OP_LSH, OP_RSH, OP_STOR, OP_SUB};
    logic [7:0] op;
    logic [1:0] k;
    repeat (n) begin
      k = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0) k = KIND_EXEC;
      op = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : ops[$urandom_range(0, 19)];
      send(k, op, random_address(), random_word());
    end
  endtask

  initial begin
    int wait_cycles;
    acc_model = '0;
    mq_model = '0;
    foreach (mem_model[i]) mem_model[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1000);
    idle_on = 1'b0;
    test_random(200);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/ias_pkg.sv
rtl/ias_arith.sv
rtl/ias_instruction_executor_top.sv
tb/sv/tb.sv
